[rtl/lte_pkg.sv]
// shared constants for the p1 triangle stiffness entry pipeline
`default_nettype none
package lte_pkg;
    localparam int OUT_BITS   = 48;
    localparam int FRAC_SHIFT = 31;
    localparam int PRE_SHIFT  = OUT_BITS - FRAC_SHIFT;
    localparam logic [OUT_BITS-1:0] POS_LIM = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic [OUT_BITS-1:0] NEG_LIM = {1'b1, {(OUT_BITS-1){1'b0}}};
endpackage
`default_nettype wire

[rtl/linear_triangle_stiffness_entry.sv]
// p1 triangle laplace stiffness entry, fully pipelined with a restoring divider
`default_nettype none
// One stiffness entry per request: grad(row).grad(col) / (2|det|) in signed Q16.32,
// saturated, with a degenerate flag and a zero entry when the determinant is zero.
// A request can be taken every cycle while i_stall does not hold a valid output. The
// pipeline has one stage for vertex differences and gradient sums, one for the four
// products, one for the determinant and dot product, one for the overflow check, 48
// one-bit divider stages, and one output stage. When the output is held by i_stall the whole pipeline holds.
module linear_triangle_stiffness_entry import lte_pkg::*; #(
    parameter int NODE_ID_BITS = 20,
    parameter int COORD_BITS   = 32
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    output logic                          o_stall,
    input  wire        [NODE_ID_BITS-1:0] i_node_a_id,
    input  wire        [NODE_ID_BITS-1:0] i_node_b_id,
    input  wire        [NODE_ID_BITS-1:0] i_node_c_id,
    input  wire        [NODE_ID_BITS-1:0] i_row_node_id,
    input  wire        [NODE_ID_BITS-1:0] i_col_node_id,
    input  wire signed [COORD_BITS-1:0]   i_ax,
    input  wire signed [COORD_BITS-1:0]   i_ay,
    input  wire signed [COORD_BITS-1:0]   i_bx,
    input  wire signed [COORD_BITS-1:0]   i_by_coord,
    input  wire signed [COORD_BITS-1:0]   i_cx,
    input  wire signed [COORD_BITS-1:0]   i_cy,
    output logic                          o_valid,
    input  wire                           i_stall,
    output logic signed [OUT_BITS-1:0]    o_stiffness_entry,
    output logic                          o_degenerate
);
    localparam int EW   = COORD_BITS + 1;     // vertex difference
    localparam int GW   = COORD_BITS + 3;     // summed gradient
    localparam int PW   = 2 * EW;             // determinant product
    localparam int QW   = 2 * GW;             // dot product term
    localparam int DETW = PW + 1;
    localparam int DOTW = QW + 1;
    localparam int DW   = 2 * COORD_BITS + 2; // |det|
    localparam int RW   = DW + 1;             // partial remainder
    localparam int MW   = DOTW;               // |dot|
    localparam int CW   = (MW > RW) ? MW : RW;

    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // stage 1: differences and gradient sums
    logic signed [EW-1:0] n_dxb, n_dyc, n_dxc, n_dyb;
    logic signed [GW-1:0] n_rx, n_ry, n_qx, n_qy;
    logic signed [EW-1:0] gx0, gy0, gx1, gy1, gx2, gy2;
    logic signed [EW-1:0] e_ax, e_ay, e_bx, e_by, e_cx, e_cy;
    logic ra, rb, rc, ca, cb, cc;

    always_comb begin
        e_ax = EW'(i_ax);
        e_ay = EW'(i_ay);
        e_bx = EW'(i_bx);
        e_by = EW'(i_by_coord);
        e_cx = EW'(i_cx);
        e_cy = EW'(i_cy);
        n_dxb = e_bx - e_ax;
        n_dyc = e_cy - e_ay;
        n_dxc = e_cx - e_ax;
        n_dyb = e_by - e_ay;
        gx0 = e_by - e_cy;
        gy0 = e_cx - e_bx;
        gx1 = e_cy - e_ay;
        gy1 = e_ax - e_cx;
        gx2 = e_ay - e_by;
        gy2 = e_bx - e_ax;
        ra = (i_node_a_id == i_row_node_id);
        rb = (i_node_b_id == i_row_node_id);
        rc = (i_node_c_id == i_row_node_id);
        ca = (i_node_a_id == i_col_node_id);
        cb = (i_node_b_id == i_col_node_id);
        cc = (i_node_c_id == i_col_node_id);
        n_rx = (ra ? GW'(gx0) : '0) + (rb ? GW'(gx1) : '0) + (rc ? GW'(gx2) : '0);
        n_ry = (ra ? GW'(gy0) : '0) + (rb ? GW'(gy1) : '0) + (rc ? GW'(gy2) : '0);
        n_qx = (ca ? GW'(gx0) : '0) + (cb ? GW'(gx1) : '0) + (cc ? GW'(gx2) : '0);
        n_qy = (ca ? GW'(gy0) : '0) + (cb ? GW'(gy1) : '0) + (cc ? GW'(gy2) : '0);
    end

    logic                 r_v1;
    logic signed [EW-1:0] r_dxb, r_dyc, r_dxc, r_dyb;
    logic signed [GW-1:0] r_rx, r_ry, r_qx, r_qy;

    // stage 2: products
    logic                 r_v2;
    logic signed [PW-1:0] r_p1, r_p2;
    logic signed [QW-1:0] r_p3, r_p4;

    // stage 3: determinant and dot product magnitudes
    logic                   r_v3, r_zero3, r_neg3;
    logic        [DW-1:0]   r_dmag3;
    logic        [MW-1:0]   r_nmag3;
    logic signed [DETW-1:0] n_det;
    logic signed [DOTW-1:0] n_dot;
    logic        [DETW-1:0] n_dabs;
    logic        [DOTW-1:0] n_nabs;

    always_comb begin
        n_det  = DETW'(r_p1) - DETW'(r_p2);
        n_dot  = DOTW'(r_p3) + DOTW'(r_p4);
        n_dabs = n_det[DETW-1] ? DETW'(-n_det) : DETW'(n_det);
        n_nabs = n_dot[DOTW-1] ? DOTW'(-n_dot) : DOTW'(n_dot);
    end

    // divider pipeline, index 0 is the overflow check stage
    logic                r_vd   [0:OUT_BITS];
    logic                r_zd   [0:OUT_BITS];
    logic                r_ngd  [0:OUT_BITS];
    logic                r_satd [0:OUT_BITS];
    logic [DW-1:0]       r_dd   [0:OUT_BITS];
    logic [RW-1:0]       r_rem  [0:OUT_BITS];
    logic [OUT_BITS-1:0] r_quo  [0:OUT_BITS];
    logic [PRE_SHIFT-1:0] r_low [0:OUT_BITS];

    logic [MW-1:0] n_hi;
    logic          n_sat;
    always_comb begin
        n_hi  = r_nmag3 >> PRE_SHIFT;
        n_sat = CW'(n_hi) >= CW'(r_dmag3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_vd[0] <= 1'b0;
        end else if (en) begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_vd[0] <= r_v3;
        end
        if (en) begin
            r_dxb <= n_dxb;
            r_dyc <= n_dyc;
            r_dxc <= n_dxc;
            r_dyb <= n_dyb;
            r_rx  <= n_rx;
            r_ry  <= n_ry;
            r_qx  <= n_qx;
            r_qy  <= n_qy;
            r_p1  <= PW'(r_dxb * r_dyc);
            r_p2  <= PW'(r_dxc * r_dyb);
            r_p3  <= QW'(r_rx * r_qx);
            r_p4  <= QW'(r_ry * r_qy);
            r_zero3 <= (n_det == '0);
            r_neg3  <= n_dot[DOTW-1];
            r_dmag3 <= DW'(n_dabs);
            r_nmag3 <= MW'(n_nabs);
            r_zd[0]   <= r_zero3;
            r_ngd[0]  <= r_neg3;
            r_satd[0] <= n_sat && !r_zero3;
            r_dd[0]   <= r_dmag3;
            r_rem[0]  <= (n_sat || r_zero3) ? '0 : RW'(n_hi);
            r_quo[0]  <= '0;
            r_low[0]  <= r_nmag3[PRE_SHIFT-1:0];
        end
    end

    for (genvar s = 0; s < OUT_BITS; s++) begin : g_div
        localparam int K = OUT_BITS - 1 - s;
        logic          nbit;
        logic [RW-1:0] trial;
        logic          ge;
        if (K >= FRAC_SHIFT) begin : g_bit
            assign nbit = r_low[s][K-FRAC_SHIFT];
        end else begin : g_zero
            assign nbit = 1'b0;
        end
        assign trial = {r_rem[s][RW-2:0], nbit};
        assign ge    = trial >= RW'(r_dd[s]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vd[s+1] <= 1'b0;
            end else if (en) begin
                r_vd[s+1] <= r_vd[s];
            end
            if (en) begin
                r_zd[s+1]   <= r_zd[s];
                r_ngd[s+1]  <= r_ngd[s];
                r_satd[s+1] <= r_satd[s];
                r_dd[s+1]   <= r_dd[s];
                r_low[s+1]  <= r_low[s];
                r_rem[s+1]  <= ge ? (trial - RW'(r_dd[s])) : trial;
                r_quo[s+1]  <= {r_quo[s][OUT_BITS-2:0], ge};
            end
        end
    end

    // output stage: saturate and apply sign
    logic [OUT_BITS-1:0] n_lim, n_mag, n_ent;
    always_comb begin
        n_lim = r_ngd[OUT_BITS] ? NEG_LIM : POS_LIM;
        n_mag = (r_satd[OUT_BITS] || r_quo[OUT_BITS] > n_lim) ? n_lim : r_quo[OUT_BITS];
        n_ent = r_ngd[OUT_BITS] ? (~n_mag + 1'b1) : n_mag;
    end

    logic                       r_ov, r_odeg;
    logic signed [OUT_BITS-1:0] r_oent;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_vd[OUT_BITS];
        end
        if (en) begin
            r_odeg <= r_zd[OUT_BITS];
            r_oent <= r_zd[OUT_BITS] ? '0 : $signed(n_ent);
        end
    end

    assign o_valid           = r_ov;
    assign o_degenerate      = r_odeg;
    assign o_stiffness_entry = r_oent;

    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_stiffness_entry == '0)
        else $error("degenerate result with nonzero entry");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vd[OUT_BITS] && !r_zd[OUT_BITS] |-> r_rem[OUT_BITS] < RW'(r_dd[OUT_BITS]))
        else $error("divider remainder not below divisor");
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_v1)
        else $error("accepted request lost at pipeline entry");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_vd[0]) && $stable(r_v3))
        else $error("pipeline moved while stalled");
endmodule
`default_nettype wire

[dv/linear_triangle_stiffness_entry_tb.sv]
// testbench for the p1 triangle stiffness entry pipeline: random and corner requests, scoreboard
`timescale 1ns / 100ps
module linear_triangle_stiffness_entry_tb import lte_pkg::*; ();

    typedef struct {
        logic [19:0]        ida, idb, idc, rid, cid;
        logic signed [31:0] ax, ay, bx, by, cx, cy;
    } t_tri_req;

    typedef struct {
        logic signed [OUT_BITS-1:0] entry;
        logic                       degen;
    } t_entry_res;

    class t_stiffness_board;
        t_entry_res pending[$];
        int         errors = 0;

        function automatic t_entry_res predict_entry(t_tri_req r);
            logic signed [127:0] xa, ya, xb, yb, xc, yc, det, dot;
            logic signed [127:0] gx[3], gy[3];
            logic signed [127:0] rx, ry, qx, qy;
            logic [127:0]        mdet, mdot, quo, lim, mag;
            logic [19:0]         ids[3];
            t_entry_res          res;
            bit                  neg;
            xa = r.ax; ya = r.ay; xb = r.bx; yb = r.by; xc = r.cx; yc = r.cy;
            det = (xb - xa) * (yc - ya) - (xc - xa) * (yb - ya);
            res.entry = '0;
            res.degen = 1'b0;
            if (det == 0) begin
                res.degen = 1'b1;
                return res;
            end
            mdet = (det < 0) ? -det : det;
            gx[0] = yb - yc; gy[0] = xc - xb;
            gx[1] = yc - ya; gy[1] = xa - xc;
            gx[2] = ya - yb; gy[2] = xb - xa;
            ids[0] = r.ida; ids[1] = r.idb; ids[2] = r.idc;
            rx = 0; ry = 0; qx = 0; qy = 0;
            for (int k = 0; k < 3; k++) begin
                if (ids[k] == r.rid) begin
                    rx += gx[k]; ry += gy[k];
                end
                if (ids[k] == r.cid) begin
                    qx += gx[k]; qy += gy[k];
                end
            end
            dot = rx * qx + ry * qy;
            neg = dot < 0;
            mdot = neg ? -dot : dot;
            quo = (mdot << FRAC_SHIFT) / mdet;
            lim = neg ? {80'b0, NEG_LIM} : {80'b0, POS_LIM};
            mag = (quo > lim) ? lim : quo;
            res.entry = neg ? OUT_BITS'(-mag) : OUT_BITS'(mag);
            return res;
        endfunction

        function void note_request(t_tri_req r);
            pending.push_back(predict_entry(r));
        endfunction

        function void check_entry(logic signed [OUT_BITS-1:0] entry, logic degen);
            t_entry_res e;
            if (pending.size() == 0) begin
                $error("entry with no request outstanding: %0d", entry);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (entry !== e.entry) begin
                $error("stiffness_entry: expected %0d, got %0d", e.entry, entry);
                errors++;
            end
            if (degen !== e.degen) begin
                $error("degenerate: expected %0d, got %0d", e.degen, degen);
                errors++;
            end
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       i_stall = 1'b0;
    logic [19:0]                i_node_a_id = '0, i_node_b_id = '0, i_node_c_id = '0;
    logic [19:0]                i_row_node_id = '0, i_col_node_id = '0;
    logic signed [31:0]         i_ax = '0, i_ay = '0, i_bx = '0;
    logic signed [31:0]         i_by_coord = '0, i_cx = '0, i_cy = '0;
    logic                       o_stall, o_valid, o_degenerate;
    logic signed [OUT_BITS-1:0] o_stiffness_entry;

    t_stiffness_board board = new();
    bit               calm = 1'b0;
    int               idle_cycles = 0;

    linear_triangle_stiffness_entry dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // accepted requests and entries, sampled with pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                t_tri_req r;
                r.ida = i_node_a_id; r.idb = i_node_b_id; r.idc = i_node_c_id;
                r.rid = i_row_node_id; r.cid = i_col_node_id;
                r.ax = i_ax; r.ay = i_ay; r.bx = i_bx;
                r.by = i_by_coord; r.cx = i_cx; r.cy = i_cy;
                board.note_request(r);
            end
            if (o_valid && !i_stall)
                board.check_entry(o_stiffness_entry, o_degenerate);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= 3000) begin
                $display("linear_triangle_stiffness_entry_tb: done, errors");
                $finish;
            end
        end
    end

    // output side back-pressure in bursts
    always @(posedge i_clk) begin
        if (calm || $urandom_range(0, 2) != 0) begin
            i_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end else begin
            i_stall <= 1'b1;
            repeat ($urandom_range(0, 11)) @(posedge i_clk);
        end
    end

    task automatic send_request(t_tri_req r);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_node_a_id <= r.ida; i_node_b_id <= r.idb; i_node_c_id <= r.idc;
        i_row_node_id <= r.rid; i_col_node_id <= r.cid;
        i_ax <= r.ax; i_ay <= r.ay; i_bx <= r.bx;
        i_by_coord <= r.by; i_cx <= r.cx; i_cy <= r.cy;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
    endtask

    function automatic t_tri_req make_tri(logic [19:0] a, b, c, row, col,
                                          logic signed [31:0] ax, ay, bx, by, cx, cy);
        t_tri_req r;
        r.ida = a; r.idb = b; r.idc = c; r.rid = row; r.cid = col;
        r.ax = ax; r.ay = ay; r.bx = bx; r.by = by; r.cx = cx; r.cy = cy;
        return r;
    endfunction

    function automatic logic [19:0] pick_id(t_tri_req r);
        case ($urandom_range(0, 4))
            0: return r.ida;
            1: return r.idb;
            2: return r.idc;
            3: return 20'($urandom_range(0, 3));
            default: return 20'($urandom);
        endcase
    endfunction

    function automatic t_tri_req random_tri();
        t_tri_req r;
        int       mode;
        mode = $urandom_range(0, 9);
        if ($urandom_range(0, 2) == 0) begin
            r.ida = 20'($urandom_range(0, 3));
            r.idb = 20'($urandom_range(0, 3));
            r.idc = 20'($urandom_range(0, 3));
        end else begin
            r.ida = 20'($urandom); r.idb = 20'($urandom); r.idc = 20'($urandom);
        end
        if (mode < 4) begin
            r.ax = $urandom; r.ay = $urandom; r.bx = $urandom;
            r.by = $urandom; r.cx = $urandom; r.cy = $urandom;
        end else if (mode < 7) begin
            // unit-scale coordinates
            r.ax = $signed(32'($urandom_range(0, 32'h0008_0000))) - 32'sh0004_0000;
            r.ay = $signed(32'($urandom_range(0, 32'h0008_0000))) - 32'sh0004_0000;
            r.bx = $signed(32'($urandom_range(0, 32'h0008_0000))) - 32'sh0004_0000;
            r.by = $signed(32'($urandom_range(0, 32'h0008_0000))) - 32'sh0004_0000;
            r.cx = $signed(32'($urandom_range(0, 32'h0008_0000))) - 32'sh0004_0000;
            r.cy = $signed(32'($urandom_range(0, 32'h0008_0000))) - 32'sh0004_0000;
        end else if (mode < 9) begin
            // sliver: c sits next to b, tiny area drives saturation
            r.ax = $urandom; r.ay = $urandom; r.bx = $urandom; r.by = $urandom;
            r.cx = r.bx + $signed(32'($urandom_range(0, 6))) - 3;
            r.cy = r.by + $signed(32'($urandom_range(0, 6))) - 3;
        end else begin
            // collinear
            r.ax = $urandom; r.ay = $urandom; r.bx = $urandom; r.by = $urandom;
            r.cx = r.ax + (r.bx - r.ax) * 2;
            r.cy = r.ay + (r.by - r.ay) * 2;
        end
        r.rid = pick_id(r);
        r.cid = pick_id(r);
        return r;
    endfunction

    localparam logic signed [31:0] ONE  = 32'sh0001_0000;
    localparam logic signed [31:0] CMAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] CMIN = 32'sh8000_0000;

    initial begin
        t_tri_req dir[$];
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unit right triangle, diagonal and off-diagonal pairs
        dir.push_back(make_tri(1, 2, 3, 1, 1, 0, 0, ONE, 0, 0, ONE));
        dir.push_back(make_tri(1, 2, 3, 1, 2, 0, 0, ONE, 0, 0, ONE));
        dir.push_back(make_tri(1, 2, 3, 2, 3, 0, 0, ONE, 0, 0, ONE));
        dir.push_back(make_tri(1, 2, 3, 3, 3, 0, ONE, ONE, 0, 0, 0));
        // absent id
        dir.push_back(make_tri(1, 2, 3, 9, 1, 0, 0, ONE, 0, 0, ONE));
        // id on all three vertices
        dir.push_back(make_tri(5, 5, 5, 5, 5, 0, 0, ONE, 0, 0, ONE));
        // two vertices share an id
        dir.push_back(make_tri(4, 4, 7, 4, 7, 0, 0, ONE, 0, 0, ONE));
        // degenerate: point, collinear
        dir.push_back(make_tri(1, 2, 3, 1, 2, ONE, ONE, ONE, ONE, ONE, ONE));
        dir.push_back(make_tri(1, 2, 3, 1, 1, 0, 0, ONE, ONE, 2 * ONE, 2 * ONE));
        // extreme coordinates and ids
        dir.push_back(make_tri(20'hfffff, 0, 20'h80000, 20'hfffff, 0,
                               CMIN, CMIN, CMAX, CMIN, CMIN, CMAX));
        dir.push_back(make_tri(0, 20'hfffff, 1, 20'hfffff, 20'hfffff,
                               CMAX, CMAX, CMIN, CMAX, CMAX, CMIN));
        // slivers, saturation both ways
        dir.push_back(make_tri(1, 2, 3, 2, 2, 0, 0, CMAX, CMAX, CMAX, CMAX - 1));
        dir.push_back(make_tri(1, 2, 3, 2, 3, 0, 0, CMAX, CMAX, CMAX, CMAX - 1));
        dir.push_back(make_tri(1, 2, 3, 1, 3, CMIN, 0, CMAX, 1, CMAX, 0));
        dir.push_back(make_tri(1, 2, 3, 1, 1, 0, 0, 1, 0, 0, 1));
        foreach (dir[i]) send_request(dir[i]);

        for (int n = 0; n < 1900; n++) begin
            if (n == 1650) calm = 1'b1;
            send_request(random_tri());
        end
        i_valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("linear_triangle_stiffness_entry_tb: done, clean");
        else
            $display("linear_triangle_stiffness_entry_tb: done, errors");
        $finish;
    end
endmodule

[filelist.f]
rtl/lte_pkg.sv
rtl/linear_triangle_stiffness_entry.sv
dv/linear_triangle_stiffness_entry_tb.sv
